// File: rtl/core/box3_pkg.sv
// Shared types and constants for the 3x3 box-sum block.
// No dependencies; imported by the top level.
package box3_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_W_BITS   = 11;
	localparam int CFG_H_BITS   = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_ADDR_W   = 4;
	localparam int MAX_WIDTH_DEF = 1024;

	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = CFG_ADDR_W'(1);

	localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = CFG_W_BITS'(640);
	localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = CFG_H_BITS'(480);

	// output queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = 3;

	typedef struct packed {
		logic [PIX_W-1:0] blurred;
		logic             run_last;
		logic             frame_end;
	} result_t;

endpackage

// File: rtl/core/box3_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same address returns the old word. No dependencies.
module box3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/box_sum_3x3_zero_border_unit.sv
// 3x3 box sum with zero border over a raster pixel stream.
// Depends on box3_pkg and box3_ram.
//
// Usage:
//  - Input channel (in_valid / in_stall / pixel): one pixel per transaction in
//    raster order, frame_height rows of frame_width pixels, then one flush row
//    of frame_width transactions whose pixel value is ignored.
//  - Output channel (out_valid / out_stall / blurred, run_last, frame_end):
//    pixel (x,y) yields output (x-1,y-1); the last column of a row also yields
//    (x,y-1). Row 0 yields nothing. run_last marks the final result of an
//    input transaction, frame_end the final output of a frame.
//  - Config port (cfg_we / cfg_addr / cfg_wdata): index 0 frame_width,
//    index 1 frame_height. Any valid write restarts the frame. Write only
//    while the block is idle.
//  - Timing: the line-store read and the sums take the cycle after a pixel
//    is accepted; its results enter the output queue at the next edge.
//  - Throughput: one pixel per cycle while in_stall is low; the line-store
//    RAM does one read and one write per cycle, the output queue absorbs the
//    extra row-end result.
//  - Output stall: results wait in an 8-entry queue; in_stall rises when the
//    queue could not take two results each for stage 1 and a new transaction.
//  - Reset: config returns to 640x480, position to the frame start, queue
//    empties. Line-store rows above the image are forced to zero instead.
module box_sum_3x3_zero_border_unit
	import box3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// pixel input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel,
	// result output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      blurred,
	output logic                  run_last,
	output logic                  frame_end
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int LW    = (CW + 1 > CFG_W_BITS) ? CW + 1 : CFG_W_BITS;
	localparam int WORD  = 2 * PIX_W;
	localparam int CNT_W = OQ_AW + 1;
	localparam logic [CNT_W-1:0] THR_IDLE = CNT_W'(OQ_DEPTH - 2);
	localparam logic [CNT_W-1:0] THR_BUSY = CNT_W'(OQ_DEPTH - 4);

	// ---------------- configuration ----------------
	logic [CFG_W_BITS-1:0] cfg_w_q;
	logic [CFG_H_BITS-1:0] cfg_h_q;
	logic                  cfg_hit;

	assign cfg_hit = cfg_we && (cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= FRAME_WIDTH_RST;
			cfg_h_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_addr == REG_FRAME_WIDTH) begin
				cfg_w_q <= cfg_wdata[CFG_W_BITS-1:0];
			end
			if (cfg_addr == REG_FRAME_HEIGHT) begin
				cfg_h_q <= cfg_wdata[CFG_H_BITS-1:0];
			end
		end
	end

	// effective last column: width 0 acts as 1, clamp to MAX_WIDTH
	logic [LW-1:0]         w_ext;
	logic [LW-1:0]         w_last_ext;
	logic [CW-1:0]         w_last;
	logic [CFG_H_BITS-1:0] h_eff;

	always_comb begin
		w_ext = LW'(cfg_w_q);
		if (w_ext == '0) begin
			w_last_ext = '0;
		end else if (w_ext > LW'(MAX_WIDTH)) begin
			w_last_ext = LW'(MAX_WIDTH - 1);
		end else begin
			w_last_ext = w_ext - LW'(1);
		end
		w_last = w_last_ext[CW-1:0];
		h_eff  = (cfg_h_q == '0) ? CFG_H_BITS'(1) : cfg_h_q;
	end

	// ---------------- raster position (accept side) ----------------
	logic [CW-1:0]         x_q;
	logic [CFG_H_BITS-1:0] y_q;
	logic                  in_acc;
	logic                  row_end_now;
	logic                  flush_now;

	assign in_acc      = in_valid && !in_stall;
	assign row_end_now = (x_q == w_last);
	assign flush_now   = (y_q >= h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_hit) begin
			x_q <= '0;
			y_q <= '0;
		end else if (in_acc) begin
			if (row_end_now) begin
				x_q <= '0;
				y_q <= flush_now ? '0 : y_q + CFG_H_BITS'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

	// ---------------- line store: {row y-2, row y-1} per column ----------------
	logic            ram_we;
	logic [CW-1:0]   ram_waddr;
	logic [WORD-1:0] ram_wdata;
	logic [WORD-1:0] ram_rdata;

	box3_ram #(
		.WIDTH (WORD),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (x_q),
		.rdata (ram_rdata)
	);

	// ---------------- stage 1 ----------------
	logic             valid_s1;
	logic [CW-1:0]    x_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             ge1_s1, ge2_s1, first_s1, row_end_s1, flush_s1;
	logic             fwd_hit_s1;
	logic [WORD-1:0]  fwd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	// same-column write in the accept cycle only happens at width one;
	// the RAM returns the old word then, so forward the fresh one
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1       <= x_q;
			pix_s1     <= flush_now ? '0 : pixel;
			ge1_s1     <= (y_q != '0);
			ge2_s1     <= (y_q[CFG_H_BITS-1:1] != '0);
			first_s1   <= (x_q == '0);
			row_end_s1 <= row_end_now;
			flush_s1   <= flush_now;
			fwd_hit_s1 <= ram_we && (ram_waddr == x_q);
			fwd_s1     <= ram_wdata;
		end
	end

	logic [WORD-1:0]  word_s1;
	logic [PIX_W-1:0] above, above2, col;
	logic [PIX_W-1:0] w1, w2, sum3, sum2;
	logic [PIX_W-1:0] win1_q, win2_q;
	logic             push_a, push_b;
	result_t          res_a, res_b;

	always_comb begin
		word_s1 = fwd_hit_s1 ? fwd_s1 : ram_rdata;
		above   = ge1_s1 ? word_s1[PIX_W-1:0] : '0;
		above2  = ge2_s1 ? word_s1[WORD-1:PIX_W] : '0;
		col     = above2 + above + pix_s1;
		w1      = first_s1 ? '0 : win1_q;
		w2      = first_s1 ? '0 : win2_q;
		sum3    = w1 + w2 + col;
		sum2    = w2 + col;

		push_a  = valid_s1 && ge1_s1 && !first_s1;
		push_b  = valid_s1 && ge1_s1 && row_end_s1;

		res_a.blurred   = sum3;
		res_a.run_last  = !row_end_s1;
		res_a.frame_end = 1'b0;
		res_b.blurred   = sum2;
		res_b.run_last  = 1'b1;
		res_b.frame_end = flush_s1;

		ram_we    = valid_s1;
		ram_waddr = x_s1;
		ram_wdata = {above, pix_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win1_q <= '0;
			win2_q <= '0;
		end else if (valid_s1) begin
			win1_q <= w2;
			win2_q <= col;
		end
	end

	// ---------------- output queue ----------------
	result_t          oq_mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] oq_wp_q, oq_rp_q;
	logic [CNT_W-1:0] oq_count_q;
	logic             push0, push1, pop;
	result_t          d0;
	logic [OQ_AW-1:0] wp_plus1;
	logic [1:0]       push_n;

	always_comb begin
		push0    = push_a || push_b;
		push1    = push_a && push_b;
		d0       = push_a ? res_a : res_b;
		wp_plus1 = oq_wp_q + OQ_AW'(1);
		push_n   = {1'b0, push0} + {1'b0, push1};
		pop      = out_valid && !out_stall;
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			oq_mem_q[oq_wp_q] <= d0;
		end
		if (push1) begin
			oq_mem_q[wp_plus1] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q    <= '0;
			oq_rp_q    <= '0;
			oq_count_q <= '0;
		end else begin
			oq_wp_q    <= oq_wp_q + OQ_AW'(push_n);
			oq_rp_q    <= oq_rp_q + OQ_AW'(pop);
			oq_count_q <= oq_count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	// room for the transaction in stage 1 plus the new one, two results each
	assign in_stall  = oq_count_q > (valid_s1 ? THR_BUSY : THR_IDLE);
	assign out_valid = (oq_count_q != '0);
	assign blurred   = oq_mem_q[oq_rp_q].blurred;
	assign run_last  = oq_mem_q[oq_rp_q].run_last;
	assign frame_end = oq_mem_q[oq_rp_q].frame_end;

endmodule
